// ===== rtl/kpm_pkg.sv =====
// ---------------------------------------------------------------------------
// Key map package
// Shared constants and types for the first-seen key to dense index mapper.
// ---------------------------------------------------------------------------
package kpm_pkg;

  localparam int KEY_W               = 64;
  localparam int INDEX_W             = 12;
  localparam int COUNT_W             = 13;
  localparam int CELLS               = 8;
  localparam int LANE_W              = 3;
  localparam int DEFAULT_MAX_ENTRIES = 4096;

  // Match word handed from one cell to the next along the row.
  typedef struct packed {
    logic              hit;
    logic [LANE_W-1:0] lane;
  } match_t;

endpackage

// ===== rtl/kpm_cell.sv =====
// ---------------------------------------------------------------------------
// Key map cell
// One lane of the key table: a bank of stored keys, a registered read port,
// a key compare and the priority link of the match chain.
// ---------------------------------------------------------------------------
module kpm_cell #(
  parameter int ROWS = 512,
  parameter int RW   = 9,
  parameter int XW   = 13,
  parameter int LANE = 0
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [RW-1:0]              rd_row,
  input  logic                       wr_en,
  input  logic [RW-1:0]              wr_row,
  input  logic [kpm_pkg::KEY_W-1:0]  wr_key,
  input  logic [kpm_pkg::KEY_W-1:0]  key,
  input  logic                       cmp_valid,
  input  logic [RW-1:0]              cmp_row,
  input  logic [XW-1:0]              count_x,
  input  kpm_pkg::match_t            match_in,
  output kpm_pkg::match_t            match_out
);

  localparam int LANE_W = kpm_pkg::LANE_W;

  logic [kpm_pkg::KEY_W-1:0] mem [ROWS];
  logic [kpm_pkg::KEY_W-1:0] rd_data;
  logic [XW-1:0]             slot;
  logic                      own_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_key;
    end
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

  // Global entry number of the word under compare; only filled entries count.
  assign slot    = {1'b0, cmp_row, LANE_W'(LANE)};
  assign own_hit = cmp_valid && (slot < count_x) && (rd_data == key);

  // A hit from a lower lane has priority, since it holds the earlier entry.
  always_comb begin
    match_out = match_in;
    if (!match_in.hit && own_hit) begin
      match_out.hit  = 1'b1;
      match_out.lane = LANE_W'(LANE);
    end
  end

endmodule

// ===== rtl/key_to_dense_id_mapper_unit.sv =====
// ---------------------------------------------------------------------------
// Key to dense index mapper
// Maps 64-bit keys to dense indices in first-seen order.
// ---------------------------------------------------------------------------
// Usage: drive key and batch_last and pulse start while busy is low; the
// word is taken at that clock edge. The table is a row of eight cells, each
// holding every eighth entry, and is searched one row of eight entries per
// cycle, with the match word passed along the cells in the same cycle.
// Exactly one result word follows each input word: done is high for one
// cycle, and dense_index, is_new_key, table_full, entries_in_use and
// batch_last_out are valid in that cycle. A hit ends the scan at the row that
// holds the entry, and a miss scans every filled row of cells.
// busy is high from the accepting edge until done, and a new word may be
// started in the cycle in which done is high. Results cannot be stalled.
// A synchronous reset empties the table at once (the entry count goes to
// zero); no clearing pass is needed, since only filled entries are compared.
// A new key that arrives with the table full gets table_full set and index 0.
// ---------------------------------------------------------------------------
module key_to_dense_id_mapper_unit #(
  parameter int MAX_ENTRIES = kpm_pkg::DEFAULT_MAX_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [kpm_pkg::KEY_W-1:0]    key,
  input  logic                         batch_last,
  output logic                         done,
  output logic [kpm_pkg::INDEX_W-1:0]  dense_index,
  output logic                         is_new_key,
  output logic                         table_full,
  output logic [kpm_pkg::COUNT_W-1:0]  entries_in_use,
  output logic                         batch_last_out
);

  localparam int CELLS   = kpm_pkg::CELLS;
  localparam int LANE_W  = kpm_pkg::LANE_W;
  localparam int INDEX_W = kpm_pkg::INDEX_W;
  localparam int COUNT_W = kpm_pkg::COUNT_W;
  localparam int ROWS    = (MAX_ENTRIES + CELLS - 1) / CELLS;
  localparam int RW      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IW      = RW + LANE_W;
  localparam int XW      = IW + 1;
  localparam int CW      = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t                    state;
  logic [kpm_pkg::KEY_W-1:0] cur_key;
  logic                      cur_last;
  logic [CW-1:0]             count;
  logic [RW:0]               rd_row;
  logic                      cmp_valid;
  logic [RW-1:0]             cmp_row;
  logic                      found;
  logic [IW-1:0]             hit_index;

  logic [XW-1:0]             count_x;
  logic [XW-1:0]             count_round;
  logic [RW:0]               rows_used;
  logic                      issue;
  logic                      insert;
  logic [LANE_W-1:0]         wr_lane;
  logic [RW-1:0]             wr_row;
  kpm_pkg::match_t           chain [CELLS+1];

  assign busy        = (state != S_IDLE);
  assign count_x     = XW'(count);
  assign count_round = count_x + XW'(CELLS - 1);
  assign rows_used   = count_round[XW-1:LANE_W];
  assign issue       = (state == S_SCAN) && (rd_row < rows_used);
  assign insert      = (state == S_FIN) && !found && (count < CW'(MAX_ENTRIES));
  assign wr_lane     = count_x[LANE_W-1:0];
  assign wr_row      = count_x[IW-1:LANE_W];
  assign chain[0]    = '0;

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    kpm_cell #(
      .ROWS (ROWS),
      .RW   (RW),
      .XW   (XW),
      .LANE (g)
    ) u_cell (
      .clk       (clk),
      .rd_en     (issue),
      .rd_row    (rd_row[RW-1:0]),
      .wr_en     (insert && (wr_lane == LANE_W'(g))),
      .wr_row    (wr_row),
      .wr_key    (cur_key),
      .key       (cur_key),
      .cmp_valid (cmp_valid),
      .cmp_row   (cmp_row),
      .count_x   (count_x),
      .match_in  (chain[g]),
      .match_out (chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      done      <= 1'b0;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cur_key   <= key;
            cur_last  <= batch_last;
            rd_row    <= '0;
            cmp_valid <= 1'b0;
            found     <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_valid <= issue;
          cmp_row   <= rd_row[RW-1:0];
          if (issue) begin
            rd_row <= rd_row + 1'b1;
          end
          if (chain[CELLS].hit) begin
            found     <= 1'b1;
            hit_index <= {cmp_row, chain[CELLS].lane};
            state     <= S_FIN;
          end else if (!issue && !cmp_valid) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          done           <= 1'b1;
          batch_last_out <= cur_last;
          state          <= S_IDLE;
          if (found) begin
            dense_index    <= INDEX_W'(hit_index);
            is_new_key     <= 1'b0;
            table_full     <= 1'b0;
            entries_in_use <= COUNT_W'(count);
          end else if (insert) begin
            dense_index    <= INDEX_W'(count);
            is_new_key     <= 1'b1;
            table_full     <= 1'b0;
            entries_in_use <= COUNT_W'(CW'(count + 1'b1));
            count          <= CW'(count + 1'b1);
          end else begin
            dense_index    <= '0;
            is_new_key     <= 1'b0;
            table_full     <= 1'b1;
            entries_in_use <= COUNT_W'(count);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result word only follows the finishing step of a search.
  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_FIN)
    else $error("result word without a finished search");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_new_xor_full: assert property (@(posedge clk) disable iff (rst)
    done |-> !(is_new_key && table_full))
    else $error("new key and table full in one word");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    done && is_new_key |-> count == CW'($past(count) + 1'b1))
    else $error("insert did not advance the entry count by one");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> state == S_SCAN)
    else $error("accepted word did not start a search");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Key to dense index mapper testbench
// Feeds keys to the mapper and keeps its own first-seen table to predict
// every result word. The sequence covers field extremes, hits on several cell
// rows, batch marks and random traffic with repeats, near misses and fresh
// keys under changing idle patterns.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int KEY_W         = kpm_pkg::KEY_W;
  localparam int INDEX_W       = kpm_pkg::INDEX_W;
  localparam int COUNT_W       = kpm_pkg::COUNT_W;
  localparam int TABLE_DEPTH   = kpm_pkg::DEFAULT_MAX_ENTRIES;
  localparam int SETTLE_CYCLES = TABLE_DEPTH / kpm_pkg::CELLS + 64;
  localparam int RANDOM_WORDS  = 1350;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [INDEX_W-1:0] dense_index;
    logic               is_new_key;
    logic               table_full;
    logic [COUNT_W-1:0] entries_in_use;
    logic               batch_last;
  } map_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [KEY_W-1:0]   key = '0;
  logic               batch_last = 1'b0;
  logic               busy;
  logic               done;
  logic [INDEX_W-1:0] dense_index;
  logic               is_new_key;
  logic               table_full;
  logic [COUNT_W-1:0] entries_in_use;
  logic               batch_last_out;

  key_to_dense_id_mapper_unit #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .key           (key),
    .batch_last    (batch_last),
    .done          (done),
    .dense_index   (dense_index),
    .is_new_key    (is_new_key),
    .table_full    (table_full),
    .entries_in_use(entries_in_use),
    .batch_last_out(batch_last_out)
  );

  always #6 clk = ~clk;

  // Mirror of the mapper's table: keys in first-seen order plus a reverse map.
  logic [KEY_W-1:0] keys_in_order[$];
  int unsigned      index_of_key[logic [KEY_W-1:0]];
  map_result_t      expected_results[$];

  int idle_pct     = 0;
  int error_count  = 0;
  int words_sent   = 0;
  int new_keys     = 0;
  int repeat_keys  = 0;
  int refused_keys = 0;
  int batch_marks  = 0;

  function automatic map_result_t map_key(logic [KEY_W-1:0] k, logic last);
    map_result_t r;
    r = '0;
    r.batch_last = last;
    if (index_of_key.exists(k)) begin
      r.dense_index = INDEX_W'(index_of_key[k]);
      repeat_keys++;
    end else if (keys_in_order.size() < TABLE_DEPTH) begin
      r.dense_index = INDEX_W'(keys_in_order.size());
      r.is_new_key = 1'b1;
      index_of_key[k] = keys_in_order.size();
      keys_in_order.insert(keys_in_order.size(), k);
      new_keys++;
    end else begin
      r.table_full = 1'b1;
      refused_keys++;
    end
    r.entries_in_use = COUNT_W'(keys_in_order.size());
    if (last) begin
      batch_marks++;
    end
    return r;
  endfunction

  // Mostly keys that exercise the table (repeats, near misses), some fresh ones.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned roll;
    int unsigned last_idx;
    logic [KEY_W-1:0] k;
    roll = $urandom_range(99);
    last_idx = keys_in_order.size() - 1;
    if (roll < 35 || keys_in_order.size() == 0) begin
      k = {$urandom, $urandom};
    end else if (roll < 65) begin
      k = keys_in_order[$urandom_range(last_idx)];
    end else if (roll < 78) begin
      k = keys_in_order[$urandom_range(last_idx < 15 ? last_idx : 15)];
    end else if (roll < 90) begin
      k = keys_in_order[$urandom_range(last_idx)] ^ (64'd1 << $urandom_range(63));
    end else if ($urandom_range(1) == 0) begin
      k = KEY_W'($urandom_range(31));
    end else begin
      k = ~KEY_W'($urandom_range(31));
    end
    return k;
  endfunction

  task automatic send_key(input logic [KEY_W-1:0] k, input logic last);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while (busy && $urandom_range(3) != 0) @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start <= 1'b1;
    key <= k;
    batch_last <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.insert(expected_results.size(), map_key(k, last));
    words_sent++;
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic test_field_extremes();
    idle_pct = 36;
    send_key('0, 1'b0);
    send_key('1, 1'b0);
    send_key(64'd1, 1'b0);
    send_key(64'h8000_0000_0000_0000, 1'b0);
    send_key(64'h5555_5555_5555_5555, 1'b0);
    send_key(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    send_key('0, 1'b0);
    send_key('1, 1'b1);
    // Differs from a stored key in the lowest bit only.
    send_key(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
    // Grow past one row of cells so that hits land on a later row.
    for (int i = 0; i < 9; i++) begin
      send_key(64'h0000_0001_0000_0000 << i, 1'b0);
    end
    send_key(keys_in_order[7], 1'b0);
    send_key(keys_in_order[8], 1'b0);
    send_key(keys_in_order[keys_in_order.size() - 1], 1'b1);
  endtask

  task automatic test_batch_persistence();
    logic [KEY_W-1:0] k;
    k = 64'h0123_4567_89AB_CDEF;
    send_key(keys_in_order[3], 1'b1);
    send_key(keys_in_order[3], 1'b0);
    send_key(k, 1'b1);
    send_key(k, 1'b0);
    send_key(keys_in_order[0], 1'b1);
  endtask

  task automatic test_random_traffic();
    idle_pct = 36;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 3) begin
        idle_pct = 72;
      end else if (n == RANDOM_WORDS / 2) begin
        wait_for_results();
      end else if (n == 2 * RANDOM_WORDS / 3) begin
        idle_pct = 0;
      end
      send_key(pick_key(), $urandom_range(7) == 0);
    end
  endtask

  always @(posedge clk) begin : check_results
    map_result_t got;
    map_result_t want;
    if (!rst && done) begin
      got = {dense_index, is_new_key, table_full, entries_in_use, batch_last_out};
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("%0t: unexpected result word: index %0d new %0b full %0b count %0d last %0b",
                   $realtime, got.dense_index, got.is_new_key, got.table_full,
                   got.entries_in_use, got.batch_last);
        end
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected index %0d new %0b full %0b count %0d last %0b",
                     want.dense_index, want.is_new_key, want.table_full,
                     want.entries_in_use, want.batch_last);
            $display("  actual   index %0d new %0b full %0b count %0d last %0b",
                     got.dense_index, got.is_new_key, got.table_full,
                     got.entries_in_use, got.batch_last);
          end
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_batch_persistence();
    test_random_traffic();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d words: %0d new keys, %0d repeats, %0d refused on a full table.",
             words_sent, new_keys, repeat_keys, refused_keys);
    $display("Batch marks seen: %0d; table ended with %0d entries; %0d errors.",
             batch_marks, keys_in_order.size(), error_count);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // The watchdog allows for a run in which every word missed on a growing table.
  initial begin
    #20_000_000;
    $display("Timed out with %0d results outstanding.", expected_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
